FILE: rtl/core/sleep_tick_task_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sleep tick task scheduler
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef SLEEP_TICK_TASK_SCHEDULER_MACROS_SVH
`define SLEEP_TICK_TASK_SCHEDULER_MACROS_SVH

`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent.
`define STTS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define STTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define STTS_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define STTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/core/stts_pkg.sv
// ----------------------------------------------------------------------------
// Sleep tick task scheduler package
// Operation codes, task states, field widths and the task table entry type.
// ----------------------------------------------------------------------------
package stts_pkg;

   localparam int OP_W     = 2;
   localparam int MS_W     = 32;
   localparam int NEXT_W   = 4;
   localparam int COUNT_W  = 5;
   localparam int PERIOD_W = 10;
   localparam int TICKS_W  = 30;
   localparam int TSTATE_W = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 10;

   localparam logic [OP_W-1:0] OP_START  = 2'd0;
   localparam logic [OP_W-1:0] OP_SLEEP  = 2'd1;
   localparam logic [OP_W-1:0] OP_FINISH = 2'd2;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd3;

   localparam logic [TSTATE_W-1:0] TS_SLEEPING = 2'd0;
   localparam logic [TSTATE_W-1:0] TS_RUNNING  = 2'd1;
   localparam logic [TSTATE_W-1:0] TS_FINISHED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TASK_COUNT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_PERIOD = 1'd1;

   localparam logic [TICKS_W-1:0] TICKS_MAX = 30'h3FFF_FFFF;

   typedef struct packed {
      logic [TSTATE_W-1:0] state;
      logic [TICKS_W-1:0]  ticks;
   } entry_type;

endpackage

FILE: rtl/core/sleep_tick_task_scheduler.sv
// ----------------------------------------------------------------------------
// Sleep tick task scheduler
// Task table with sleep counters, a bit-serial divider and a scan sequencer.
// ----------------------------------------------------------------------------
// A request carries an operation (start, sleep, finish, tick) and a sleep time
// in milliseconds. Each request yields exactly one response with switch_now,
// next_task and waiting. Both channels use valid and stall; the block stalls
// its request side for as long as a request is being worked on.
// The task table lives in a single-port memory with a registered read, so
// each visited entry takes a read state and a check state. A sleep or a
// finish while a pick is pending goes straight to the result, and a start
// marks task 0 running. Any other sleep reads the running entry; unless it
// is finished, the one-bit-per-cycle divider runs and the entry is written
// back. The sleep then scans the tasks. A finish marks the entry finished
// and scans without the divider. A tick sweeps all active tasks and then, if
// a pick is pending, scans again. Reset clears the task table at once through
// per-entry valid bits; no clearing pass is needed. A stalled response is
// held in the output register while the next request is accepted and worked
// on; that request then waits for the output register before finishing.
// ----------------------------------------------------------------------------
`include "sleep_tick_task_scheduler_macros.svh"

module sleep_tick_task_scheduler #(
   parameter int TASK_SLOTS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [stts_pkg::OP_W-1:0]        req_op,
   input  logic [stts_pkg::MS_W-1:0]        req_sleep_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_switch_now,
   output logic [stts_pkg::NEXT_W-1:0]      rsp_next_task,
   output logic                             rsp_waiting,
   input  logic                             csr_we,
   input  logic [stts_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [stts_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import stts_pkg::*;

   localparam int IW    = $clog2(TASK_SLOTS);
   localparam int CNT_W = $clog2(TASK_SLOTS + 1);
   localparam logic [31:0] MAX_U = 32'(TASK_SLOTS);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_RD_CUR   = 4'd1;
   localparam logic [3:0] ST_CHK_CUR  = 4'd2;
   localparam logic [3:0] ST_DIV      = 4'd3;
   localparam logic [3:0] ST_WR_CUR   = 4'd4;
   localparam logic [3:0] ST_SCAN_RD  = 4'd5;
   localparam logic [3:0] ST_SCAN_CHK = 4'd6;
   localparam logic [3:0] ST_TICK_RD  = 4'd7;
   localparam logic [3:0] ST_TICK_CHK = 4'd8;
   localparam logic [3:0] ST_RESULT   = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [MS_W-1:0]     quo_ff, quo_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [4:0]          div_cnt_ff, div_cnt_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [IW-1:0]       running_ff, running_in;
   logic                pending_ff, pending_in;
   logic                chosen_ff, chosen_in;
   logic [COUNT_W-1:0]  task_count_ff;
   logic [PERIOD_W-1:0] tick_period_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_switch_ff, rsp_switch_in;
   logic [NEXT_W-1:0]   rsp_next_ff, rsp_next_in;
   logic                rsp_waiting_ff, rsp_waiting_in;

   entry_type           mem [TASK_SLOTS];
   entry_type           rd_ff;
   logic                rd_vld_ff;
   logic [TASK_SLOTS-1:0] valid_ff;

   entry_type           entry;
   entry_type           mem_wdata;
   logic                mem_we;
   logic [IW-1:0]       mem_addr;
   logic [CNT_W-1:0]    active_n;
   logic [PERIOD_W-1:0] period;
   logic [PERIOD_W:0]   trial;
   logic                trial_ge;
   logic [TICKS_W-1:0]  sat_ticks;
   logic                req_take;
   logic                out_free;

   assign req_take = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign active_n = ({27'd0, task_count_ff} > MAX_U) ? CNT_W'(TASK_SLOTS)
                                                       : CNT_W'(task_count_ff);
   assign period   = (tick_period_ff == '0) ? PERIOD_W'(1) : tick_period_ff;
   assign trial    = {rem_ff, quo_ff[MS_W-1]};
   assign trial_ge = trial >= {1'b0, period};
   assign sat_ticks = (quo_ff[MS_W-1:TICKS_W] != '0) ? TICKS_MAX : quo_ff[TICKS_W-1:0];
   assign entry    = rd_vld_ff ? rd_ff : '0;

   always_comb begin
      case (state_ff)
         ST_RD_CUR, ST_CHK_CUR, ST_DIV, ST_WR_CUR: mem_addr = running_ff;
         default:                                  mem_addr = idx_ff[IW-1:0];
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      div_cnt_in     = div_cnt_ff;
      idx_in         = idx_ff;
      running_in     = running_ff;
      pending_in     = pending_ff;
      chosen_in      = chosen_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_switch_in  = rsp_switch_ff;
      rsp_next_in    = rsp_next_ff;
      rsp_waiting_in = rsp_waiting_ff;
      mem_we         = 1'b0;
      mem_wdata      = entry;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               op_in     = req_op;
               quo_in    = req_sleep_ms;
               idx_in    = '0;
               chosen_in = 1'b0;
               case (req_op)
                  OP_START: begin
                     running_in = '0;
                     pending_in = 1'b0;
                     state_in   = ST_RD_CUR;
                  end
                  OP_TICK: begin
                     state_in = ST_TICK_RD;
                  end
                  default: begin
                     state_in = pending_ff ? ST_RESULT : ST_RD_CUR;
                  end
               endcase
            end
         end
         ST_RD_CUR: begin
            state_in = ST_CHK_CUR;
         end
         ST_CHK_CUR: begin
            case (op_ff)
               OP_START: begin
                  mem_we          = 1'b1;
                  mem_wdata.state = TS_RUNNING;
                  chosen_in       = 1'b1;
                  state_in        = ST_RESULT;
               end
               OP_FINISH: begin
                  mem_we          = 1'b1;
                  mem_wdata.state = TS_FINISHED;
                  state_in        = ST_SCAN_RD;
               end
               default: begin
                  if (entry.state == TS_FINISHED) begin
                     state_in = ST_SCAN_RD;
                  end else begin
                     rem_in     = '0;
                     div_cnt_in = '0;
                     state_in   = ST_DIV;
                  end
               end
            endcase
         end
         ST_DIV: begin
            rem_in     = trial_ge ? PERIOD_W'(trial - {1'b0, period}) : trial[PERIOD_W-1:0];
            quo_in     = {quo_ff[MS_W-2:0], trial_ge};
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'd31) begin
               state_in = ST_WR_CUR;
            end
         end
         ST_WR_CUR: begin
            mem_we          = 1'b1;
            mem_wdata.state = TS_SLEEPING;
            mem_wdata.ticks = sat_ticks;
            state_in        = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            if (idx_ff >= active_n) begin
               pending_in = 1'b1;
               state_in   = ST_RESULT;
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (entry.state != TS_FINISHED && entry.ticks == '0) begin
               mem_we          = 1'b1;
               mem_wdata.state = TS_RUNNING;
               running_in      = idx_ff[IW-1:0];
               pending_in      = 1'b0;
               chosen_in       = 1'b1;
               state_in        = ST_RESULT;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_TICK_RD: begin
            if (idx_ff >= active_n) begin
               idx_in   = '0;
               state_in = pending_ff ? ST_SCAN_RD : ST_RESULT;
            end else begin
               state_in = ST_TICK_CHK;
            end
         end
         ST_TICK_CHK: begin
            if (entry.ticks != '0) begin
               mem_we          = 1'b1;
               mem_wdata.ticks = entry.ticks - TICKS_W'(1);
            end
            idx_in   = idx_ff + CNT_W'(1);
            state_in = ST_TICK_RD;
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_switch_in  = chosen_ff;
               rsp_next_in    = NEXT_W'(running_ff);
               rsp_waiting_in = pending_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         running_ff     <= '0;
         pending_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         valid_ff       <= '0;
         rd_vld_ff      <= 1'b0;
         task_count_ff  <= COUNT_W'(1);
         tick_period_ff <= PERIOD_W'(1);
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= valid_ff[mem_addr];
         if (mem_we) begin
            valid_ff[mem_addr] <= 1'b1;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_TASK_COUNT:  task_count_ff  <= csr_wdata[COUNT_W-1:0];
               CSR_TICK_PERIOD: tick_period_ff <= csr_wdata[PERIOD_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      div_cnt_ff     <= div_cnt_in;
      idx_ff         <= idx_in;
      chosen_ff      <= chosen_in;
      rsp_switch_ff  <= rsp_switch_in;
      rsp_next_ff    <= rsp_next_in;
      rsp_waiting_ff <= rsp_waiting_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= mem[mem_addr];
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_switch_now = rsp_switch_ff;
   assign rsp_next_task  = rsp_next_ff;
   assign rsp_waiting    = rsp_waiting_ff;

   `STTS_ASSERT_SAME(a_no_switch_while_waiting, clock, reset, rsp_valid_ff, !(rsp_switch_ff && rsp_waiting_ff), "response reports a switch and a pending pick together")
   `STTS_ASSERT_NEXT(a_busy_after_request, clock, reset, req_take, state_ff != ST_IDLE, "sequencer idle right after a request")
   `STTS_ASSERT_SAME(a_scan_in_range, clock, reset, state_ff == ST_SCAN_CHK || state_ff == ST_TICK_CHK, idx_ff < active_n, "table entry checked beyond the active tasks")

endmodule

FILE: tb/sleep_tick_task_scheduler_tb.sv
// ----------------------------------------------------------------------------
// Sleep tick task scheduler testbench
// A queue of requests feeds a clocked driver, and a clocked monitor checks
// every response against an in-bench model of the task table. Both sides
// idle at random. The receiver also holds off twice for a long stretch so
// that the block backs up. A directed opening covers the corner cases, and
// random phases under varied register settings follow.
// ----------------------------------------------------------------------------
module sleep_tick_task_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import stts_pkg::*;

   localparam int TASK_SLOTS  = 16;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_WAIT  = 100;
   localparam int LONG_HOLD   = 400;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [MS_W-1:0] ms;
   } sched_req_t;

   typedef struct packed {
      logic              switch_now;
      logic [NEXT_W-1:0] next_task;
      logic              waiting;
   } sched_outcome_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [OP_W-1:0]       req_op = '0;
   logic [MS_W-1:0]       req_sleep_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_switch_now;
   logic [NEXT_W-1:0]     rsp_next_task;
   logic                  rsp_waiting;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [TSTATE_W-1:0]   task_st [TASK_SLOTS];
   logic [TICKS_W-1:0]    task_ticks [TASK_SLOTS];
   logic [NEXT_W-1:0]     run_task;
   logic                  pick_wait;
   logic [COUNT_W-1:0]    cfg_task_count;
   logic [PERIOD_W-1:0]   cfg_tick_period;

   sched_req_t     sched_reqs [$];
   sched_outcome_t sched_expect [$];
   sched_req_t     cur_req = '0;

   bit req_busy  = 1'b0;
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   bit rsp_up    = 1'b0;
   int req_gap   = 0;
   int req_calm  = 0;
   int rsp_hold  = 0;
   int rsp_calm  = 0;
   int long_hold = 0;
   int rsp_count = 0;
   int cycles    = 0;
   int errors    = 0;

   sleep_tick_task_scheduler dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_sleep_ms   (req_sleep_ms),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_switch_now (rsp_switch_now),
      .rsp_next_task  (rsp_next_task),
      .rsp_waiting    (rsp_waiting),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int live_tasks();
      return (cfg_task_count > TASK_SLOTS) ? TASK_SLOTS : int'(cfg_task_count);
   endfunction

   function automatic logic pick_next_task();
      int n;
      n = live_tasks();
      for (int i = 0; i < n; i++) begin
         if (task_st[i] != TS_FINISHED && task_ticks[i] == '0) begin
            run_task   = NEXT_W'(i);
            task_st[i] = TS_RUNNING;
            pick_wait  = 1'b0;
            return 1'b1;
         end
      end
      pick_wait = 1'b1;
      return 1'b0;
   endfunction

   function automatic sched_outcome_t schedule_step(input logic [OP_W-1:0] op,
                                                    input logic [MS_W-1:0] ms);
      sched_outcome_t r;
      logic           chosen;
      logic [31:0]    period;
      logic [31:0]    span;
      int             n;
      chosen = 1'b0;
      case (op)
         OP_START: begin
            run_task   = '0;
            task_st[0] = TS_RUNNING;
            pick_wait  = 1'b0;
            chosen     = 1'b1;
         end
         OP_SLEEP: begin
            if (!pick_wait) begin
               if (task_st[run_task] != TS_FINISHED) begin
                  period = (cfg_tick_period == '0) ? 32'd1 : 32'(cfg_tick_period);
                  span   = ms / period;
                  task_st[run_task]    = TS_SLEEPING;
                  task_ticks[run_task] = (span > 32'(TICKS_MAX)) ? TICKS_MAX
                                                                 : span[TICKS_W-1:0];
               end
               chosen = pick_next_task();
            end
         end
         OP_FINISH: begin
            if (!pick_wait) begin
               task_st[run_task] = TS_FINISHED;
               chosen = pick_next_task();
            end
         end
         default: begin
            n = live_tasks();
            for (int i = 0; i < n; i++) begin
               if (task_ticks[i] != '0) task_ticks[i] = task_ticks[i] - 1'b1;
            end
            if (pick_wait) chosen = pick_next_task();
         end
      endcase
      r.switch_now = chosen;
      r.next_task  = run_task;
      r.waiting    = pick_wait;
      return r;
   endfunction

   function automatic int draw_gap(ref int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 40);
      return $urandom_range(0, 14);
   endfunction

   task automatic push_req(input logic [OP_W-1:0] op, input logic [MS_W-1:0] ms);
      sched_req_t q;
      q.op = op;
      q.ms = ms;
      sched_reqs.push_back(q);
   endtask

   task automatic wait_idle();
      while (sched_reqs.size() != 0 || req_busy || sched_expect.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_TASK_COUNT) cfg_task_count = data[COUNT_W-1:0];
      else cfg_tick_period = data[PERIOD_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Request driver.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            req_taken = 1'b0;
            req_busy  = 1'b0;
         end
         if (!req_busy && req_gap > 0) begin
            req_gap--;
         end else if (!req_busy && sched_reqs.size() != 0) begin
            cur_req  = sched_reqs.pop_front();
            req_busy = 1'b1;
            req_gap  = draw_gap(req_calm);
         end
         req_valid    <= req_busy;
         req_op       <= cur_req.op;
         req_sleep_ms <= cur_req.ms;
      end
   end

   // Response receiver.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_hold  = draw_gap(rsp_calm);
            if (rsp_count == 150 || rsp_count == 600) long_hold = LONG_HOLD;
         end
         if (long_hold > 0) long_hold--;
         else if (rsp_hold > 0 && rsp_up) rsp_hold--;
         rsp_stall <= (long_hold > 0) || (rsp_hold > 0);
      end
   end

   // Monitor and checker.
   always @(posedge clock) begin
      sched_outcome_t want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else if (!reset) begin
         if (req_valid && !req_stall) begin
            sched_expect.push_back(schedule_step(req_op, req_sleep_ms));
            req_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_taken = 1'b1;
            rsp_count++;
            if (sched_expect.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               want = sched_expect.pop_front();
               if (rsp_switch_now !== want.switch_now) begin
                  $error("switch_now: expected %0d, actual %0d", want.switch_now,
                         rsp_switch_now);
                  errors++;
               end
               if (rsp_next_task !== want.next_task) begin
                  $error("next_task: expected %0d, actual %0d", want.next_task,
                         rsp_next_task);
                  errors++;
               end
               if (rsp_waiting !== want.waiting) begin
                  $error("waiting: expected %0d, actual %0d", want.waiting, rsp_waiting);
                  errors++;
               end
            end
         end
         rsp_up = rsp_valid && rsp_stall;
      end
   end

   initial begin
      int          r;
      int unsigned per;
      logic [4:0]  cnt;
      logic [9:0]  tick_per;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         task_st[i]    = TS_SLEEPING;
         task_ticks[i] = '0;
      end
      run_task        = '0;
      pick_wait       = 1'b0;
      cfg_task_count  = 5'd1;
      cfg_tick_period = 10'd1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Operations before any start, with one task in play.
      push_req(OP_SLEEP, 32'd0);
      push_req(OP_FINISH, 32'd7);
      push_req(OP_SLEEP, 32'd3);
      push_req(OP_FINISH, 32'd0);
      push_req(OP_TICK, 32'd0);
      push_req(OP_START, 32'd0);
      wait_idle();

      write_csr(CSR_TASK_COUNT, 10'd3);
      write_csr(CSR_TICK_PERIOD, 10'd1);
      push_req(OP_START, 32'd0);
      push_req(OP_SLEEP, 32'd2);
      push_req(OP_FINISH, 32'd0);
      push_req(OP_SLEEP, 32'd1);
      push_req(OP_TICK, 32'd0);
      push_req(OP_TICK, 32'hFFFF_FFFF);
      push_req(OP_SLEEP, 32'hFFFF_FFFF);
      push_req(OP_TICK, 32'd0);
      wait_idle();

      write_csr(CSR_TASK_COUNT, {5'b10101, 5'd0});
      write_csr(CSR_TICK_PERIOD, 10'd0);
      push_req(OP_START, 32'd0);
      push_req(OP_SLEEP, 32'd40);
      push_req(OP_TICK, 32'd0);
      push_req(OP_START, 32'd0);
      wait_idle();

      write_csr(CSR_TASK_COUNT, 10'd31);
      write_csr(CSR_TICK_PERIOD, 10'd1023);
      push_req(OP_START, 32'd0);
      push_req(OP_SLEEP, 32'hFFFF_FFFF);
      push_req(OP_SLEEP, 32'd1022);
      push_req(OP_FINISH, 32'd0);
      push_req(OP_TICK, 32'd0);
      wait_idle();

      for (int phase = 0; phase < 10; phase++) begin
         r = $urandom_range(0, 19);
         if (phase == 0) cnt = 5'd16;
         else if (r == 0) cnt = 5'd0;
         else if (r < 4) cnt = 5'($urandom_range(17, 31));
         else cnt = 5'($urandom_range(1, 16));
         r = $urandom_range(0, 9);
         if (phase == 0) tick_per = 10'd1000;
         else if (r == 0) tick_per = 10'd0;
         else if (r == 1) tick_per = 10'($urandom_range(1000, 1023));
         else tick_per = 10'($urandom_range(1, 8));
         write_csr(CSR_TASK_COUNT, {5'($urandom), cnt});
         write_csr(CSR_TICK_PERIOD, tick_per);
         per = (tick_per == 10'd0) ? 1 : tick_per;
         push_req(OP_START, $urandom);
         repeat (99) begin
            r = $urandom_range(0, 99);
            if (r < 40) push_req(OP_TICK, $urandom);
            else if (r < 72) push_req(OP_SLEEP, per * $urandom_range(0, 6)
                                                + $urandom_range(0, per - 1));
            else if (r < 75) push_req(OP_SLEEP, $urandom);
            else if (r < 85) push_req(OP_FINISH, $urandom);
            else if (r < 90) push_req(OP_START, $urandom);
            else push_req(OP_W'($urandom), $urandom);
         end
         wait_idle();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
